@@ rtl/smbs_pkg.sv @@
// smbs_pkg: widths, codes and shared types for the shared-medium backoff simulator.
// No dependencies; imported by the interfaces, the wait unit and the top level.
package smbs_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LaneN   = 8;
  localparam int unsigned RandW   = ByteW * LaneN;
  localparam int unsigned CountW  = 4;
  localparam int unsigned StaW    = 3;
  localparam int unsigned ExpW    = 4;
  localparam int unsigned RoundSh = 8;

  localparam logic [CountW-1:0] DevCountReset = 4'd8;
  localparam logic [CountW-1:0] DevCountMin   = 4'd1;
  localparam logic [ByteW-1:0]  RoundHalf     = 8'd128;

  localparam logic ActAdvance = 1'b0;
  localparam logic ActRestart = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] rnd;
    logic [ExpW-1:0]  exp;
  } smbs_wait_req_t;

  typedef struct packed {
    logic [TickW-1:0] due;
    logic [ExpW-1:0]  exp_next;
  } smbs_wait_rsp_t;

endpackage

@@ rtl/smbs_if.sv @@
// smbs_if: valid/ready channel interfaces for items and results.
// Depends on smbs_pkg for field widths.
interface smbs_item_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [smbs_pkg::RandW-1:0] random_bytes;

  modport source (output valid, action, random_bytes, input ready);
  modport sink   (input valid, action, random_bytes, output ready);
endinterface

interface smbs_result_if;
  logic                        valid;
  logic                        ready;
  logic [smbs_pkg::TickW-1:0]  tick_number;
  logic [smbs_pkg::LaneN-1:0]  transmit_mask;
  logic [smbs_pkg::CountW-1:0] transmit_count;
  logic                        success;
  logic [smbs_pkg::StaW-1:0]   success_station;
  logic                        all_done;

  modport source (output valid, tick_number, transmit_mask, transmit_count, success,
                  success_station, all_done, input ready);
  modport sink   (input valid, tick_number, transmit_mask, transmit_count, success,
                  success_station, all_done, output ready);
endinterface

@@ rtl/smbs_wait_unit.sv @@
// smbs_wait_unit: shared backoff arithmetic, wait = ((r << k) + 128) >> 8,
// due = tick + 1 + wait, exponent step with saturation. Depends on smbs_pkg.
module smbs_wait_unit #(
  parameter int unsigned MaxExponent = 10
) (
  input  smbs_pkg::smbs_wait_req_t        req_i,
  input  logic [smbs_pkg::TickW-1:0]      tick_i,
  output smbs_pkg::smbs_wait_rsp_t        rsp_o
);
  import smbs_pkg::*;

  localparam int unsigned ShW   = ByteW + MaxExponent;
  localparam int unsigned WaitW = ShW + 1 - RoundSh;

  logic [ShW-1:0]   shifted;
  logic [ShW:0]     rounded;
  logic [WaitW-1:0] wait_cyc;

  always_comb begin
    shifted  = ShW'(req_i.rnd) << req_i.exp;
    rounded  = (ShW+1)'(shifted) + (ShW+1)'(RoundHalf);
    wait_cyc = rounded[ShW:RoundSh];
    rsp_o.due = tick_i + TickW'(wait_cyc) + TickW'(1);
    if (req_i.exp < ExpW'(MaxExponent)) begin
      rsp_o.exp_next = req_i.exp + ExpW'(1);
    end else begin
      rsp_o.exp_next = req_i.exp;
    end
  end

endmodule

@@ rtl/shared_medium_backoff_sim_unit.sv @@
// shared_medium_backoff_sim_unit: top level of the backoff simulator.
// Depends on smbs_pkg, smbs_if and smbs_wait_unit.
//
//  channel    dir  handshake          payload
//  items_i    in   valid/ready        action, random_bytes
//  results_o  out  valid/ready        tick_number .. all_done
//  cfg        in   cfg_we_i           cfg_wdata_i (device_count)
//
// An advance runs a scan pass and an update pass over the stations, one station a cycle,
// the update pass going through the shared wait unit; a restart skips both passes.
// Reset clears all station state and sets device_count to 8.
// The result sits in an output register; the next item is taken while it waits.
// If that register is still full at the end of an item, the sequencer holds.
module shared_medium_backoff_sim_unit #(
  parameter int unsigned MaxStations = 8,
  parameter int unsigned MaxExponent = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smbs_item_if.sink                     items_i,
  smbs_result_if.source                 results_o,
  input  logic                          cfg_we_i,
  input  logic [smbs_pkg::CountW-1:0]   cfg_wdata_i
);
  import smbs_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxStations);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MaxStations - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [CountW-1:0]      dev_cnt_q;
  logic [CountW-1:0]      n_q, n_d;
  logic [TickW-1:0]       tick_q, tick_d;
  logic [TickW-1:0]       due_q [MaxStations];
  logic [TickW-1:0]       due_d [MaxStations];
  logic [ExpW-1:0]        exp_q [MaxStations];
  logic [ExpW-1:0]        exp_d [MaxStations];
  logic [MaxStations-1:0] dlv_q, dlv_d;
  logic [MaxStations-1:0] sent_q, sent_d;
  logic [CountW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]        win_q, win_d;
  logic                   restart_q, restart_d;
  logic [ByteW-1:0]       rnd_q [MaxStations];
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;

  logic [TickW-1:0]       res_tick_q;
  logic [LaneN-1:0]       res_mask_q;
  logic [CountW-1:0]      res_cnt_q;
  logic                   res_succ_q;
  logic [StaW-1:0]        res_sta_q;
  logic                   res_done_q;

  logic [CountW-1:0]      n_clamped;
  logic [MaxStations-1:0] active;
  logic [LaneN-1:0]       mask_ext;
  logic                   station_tx;
  logic                   item_xfer;
  smbs_wait_req_t         wreq;
  smbs_wait_rsp_t         wrsp;

  assign item_xfer     = items_i.valid && items_i.ready;
  assign items_i.ready = (state_q == StIdle);

  always_comb begin
    if (dev_cnt_q < DevCountMin) begin
      n_clamped = DevCountMin;
    end else if (dev_cnt_q > CountW'(MaxStations)) begin
      n_clamped = CountW'(MaxStations);
    end else begin
      n_clamped = dev_cnt_q;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxStations; i++) begin
      active[i] = (CountW'(i) < n_q);
    end
    mask_ext = '0;
    mask_ext[MaxStations-1:0] = sent_q;
  end

  assign station_tx = (CountW'(idx_q) < n_q) && !dlv_q[idx_q] && (due_q[idx_q] == tick_q);

  assign wreq.rnd = rnd_q[idx_q];
  assign wreq.exp = exp_q[idx_q];

  smbs_wait_unit #(
    .MaxExponent(MaxExponent)
  ) u_wait (
    .req_i (wreq),
    .tick_i(tick_q),
    .rsp_o (wrsp)
  );

  assign out_load = (state_q == StFinish) && (!out_valid_q || results_o.ready);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    tick_d      = tick_q;
    due_d       = due_q;
    exp_d       = exp_q;
    dlv_d       = dlv_q;
    sent_d      = sent_q;
    cnt_d       = cnt_q;
    win_d       = win_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q;
    if (results_o.valid && results_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (item_xfer) begin
          idx_d  = '0;
          sent_d = '0;
          cnt_d  = '0;
          win_d  = '0;
          n_d    = n_clamped;
          if (items_i.action == ActRestart) begin
            restart_d = 1'b1;
            tick_d    = '0;
            dlv_d     = '0;
            for (int i = 0; i < MaxStations; i++) begin
              due_d[i] = '0;
              exp_d[i] = '0;
            end
            state_d = StFinish;
          end else begin
            restart_d = 1'b0;
            state_d   = StScan;
          end
        end
      end
      StScan: begin
        if (station_tx) begin
          sent_d[idx_q] = 1'b1;
          cnt_d         = cnt_q + CountW'(1);
          win_d         = idx_q;
        end
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          state_d = StUpdate;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StUpdate: begin
        if (sent_q[idx_q]) begin
          if (cnt_q == CountW'(1)) begin
            dlv_d[idx_q] = 1'b1;
          end else begin
            due_d[idx_q] = wrsp.due;
            exp_d[idx_q] = wrsp.exp_next;
          end
        end
        if (idx_q == IdxLast) begin
          state_d = StFinish;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StFinish: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (!restart_q) begin
            tick_d = tick_q + TickW'(1);
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      n_q         <= DevCountReset;
      tick_q      <= '0;
      dlv_q       <= '0;
      sent_q      <= '0;
      cnt_q       <= '0;
      win_q       <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dev_cnt_q   <= DevCountReset;
      for (int i = 0; i < MaxStations; i++) begin
        due_q[i] <= '0;
        exp_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      tick_q      <= tick_d;
      due_q       <= due_d;
      exp_q       <= exp_d;
      dlv_q       <= dlv_d;
      sent_q      <= sent_d;
      cnt_q       <= cnt_d;
      win_q       <= win_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dev_cnt_q <= cfg_wdata_i;
      end
    end
  end

  // random bytes and result fields: payload only
  always_ff @(posedge clk_i) begin
    if (item_xfer) begin
      for (int i = 0; i < MaxStations; i++) begin
        rnd_q[i] <= items_i.random_bytes[i*ByteW +: ByteW];
      end
    end
    if (out_load) begin
      if (restart_q) begin
        res_tick_q <= '0;
        res_mask_q <= '0;
        res_cnt_q  <= '0;
        res_succ_q <= 1'b0;
        res_sta_q  <= '0;
        res_done_q <= 1'b0;
      end else begin
        res_tick_q <= tick_q;
        res_mask_q <= mask_ext;
        res_cnt_q  <= cnt_q;
        res_succ_q <= (cnt_q == CountW'(1));
        res_sta_q  <= (cnt_q == CountW'(1)) ? StaW'(win_q) : '0;
        res_done_q <= &(dlv_q | ~active);
      end
    end
  end

  assign results_o.valid           = out_valid_q;
  assign results_o.tick_number     = res_tick_q;
  assign results_o.transmit_mask   = res_mask_q;
  assign results_o.transmit_count  = res_cnt_q;
  assign results_o.success         = res_succ_q;
  assign results_o.success_station = res_sta_q;
  assign results_o.all_done        = res_done_q;

endmodule

@@ rtl/smbs_checker.sv @@
// smbs_checker: port-level assertions for the backoff simulator, bound to the top.
// Depends on smbs_pkg and shared_medium_backoff_sim_unit.
module smbs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [smbs_pkg::LaneN-1:0]    mask_i,
  input logic [smbs_pkg::CountW-1:0]   count_i,
  input logic                          success_i,
  input logic [smbs_pkg::StaW-1:0]     station_i
);
  import smbs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while previous one in progress");

  a_count_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (CountW'($countones(mask_i)) == count_i))
    else $error("transmit count disagrees with mask");

  a_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (success_i == (count_i == CountW'(1)))
                 && (success_i || station_i == '0))
    else $error("success flag or station inconsistent");

endmodule

bind shared_medium_backoff_sim_unit smbs_checker u_smbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (items_i.valid),
  .in_ready_i (items_i.ready),
  .out_valid_i(results_o.valid),
  .out_ready_i(results_o.ready),
  .mask_i     (results_o.transmit_mask),
  .count_i    (results_o.transmit_count),
  .success_i  (results_o.success),
  .station_i  (results_o.success_station)
);
